FILE: src/av_sync_frame_decider_top_assert.svh
// Assertion macros for the frame decider.
`ifndef AV_SYNC_FRAME_DECIDER_TOP_ASSERT_SVH
`define AV_SYNC_FRAME_DECIDER_TOP_ASSERT_SVH

`define AVS_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define AVS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: src/avsfd_pkg.sv
package avsfd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [1:0] MODE_EVAL   = 2'd0;
  localparam logic [1:0] MODE_RST_TL = 2'd1;
  localparam logic [1:0] MODE_RST_ST = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] ACT_RENDER = 2'd0;
  localparam logic [1:0] ACT_WAIT   = 2'd1;
  localparam logic [1:0] ACT_DROP   = 2'd2;

  localparam logic [2:0] REG_EARLY = 3'd0;
  localparam logic [2:0] REG_LATE  = 3'd1;
  localparam logic [2:0] REG_JUMP  = 3'd2;
  localparam logic [2:0] REG_BACK  = 3'd3;
  localparam logic [2:0] REG_ALIGN = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] video_time;
    logic [63:0] audio_time;
    logic        audio_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        synced;
    logic        rebuilt;
    logic [63:0] av_delta;
    logic [63:0] mean_delta;
    logic [62:0] peak_delta;
    logic [31:0] total_count;
    logic [31:0] render_count;
    logic [31:0] wait_count;
    logic [31:0] drop_count;
    logic [31:0] unsync_count;
    logic [31:0] rebuild_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] early_threshold;
    logic [31:0] late_threshold;
    logic [31:0] jump_threshold;
    logic [31:0] backward_threshold;
    logic        align_first;
  } cfg_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic [1:0]  mode;
    logic        present;
    logic [63:0] video_time;
    logic [63:0] audio_time;
    logic [63:0] raw;
  } work_t;

endpackage

FILE: src/avsfd_if.sv
interface avsfd_in_if;
  logic               valid;
  logic               ready;
  avsfd_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface avsfd_out_if;
  logic                valid;
  logic                ready;
  avsfd_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: src/avsfd_front.sv
module avsfd_front (
  input  logic                clk,
  input  logic                rst,
  avsfd_in_if.sink            in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output avsfd_pkg::work_t    q_data
);

  avsfd_pkg::work_t slot [2];
  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  avsfd_pkg::work_t w;

  // Unused mode three is dropped here and never reaches the back.
  always_comb begin
    w.mode          = in_ch.data.mode;
    w.present       = in_ch.data.audio_present;
    w.video_time    = in_ch.data.video_time;
    w.audio_time    = in_ch.data.audio_time;
    w.raw           = in_ch.data.video_time - in_ch.data.audio_time;
  end

  assign in_ch.ready = (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (in_ch.data.mode != avsfd_pkg::MODE_UNUSED);
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= w;
    end
    if (rst) begin
      cnt <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/avsfd_back.sv
module avsfd_back #(
  parameter int COUNT_WIDTH = avsfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  avsfd_pkg::cfg_t  cfg,
  input  logic             cfg_wr,
  input  logic             q_valid,
  output logic             q_ready,
  input  avsfd_pkg::work_t q_data,
  avsfd_out_if.source      out_ch
);

  localparam int CW = COUNT_WIDTH;

  logic        tl_valid;
  logic [63:0] tl_offset;
  logic [63:0] prev_video;
  logic [63:0] prev_audio;
  logic [63:0] prev_raw;
  logic        mean_valid;
  logic [63:0] mean_store;
  logic [62:0] peak_store;
  logic [CW-1:0] c_total, c_render, c_wait, c_drop, c_unsync, c_rebuild;

  // Stage one registers.
  logic        s1;
  avsfd_pkg::work_t w1;
  logic        rb1;
  logic        build1;

  logic        take;
  logic        fire2;
  logic        out_free;

  logic [63:0] chg;
  logic        back_v, back_a, jump, need_rb;
  logic [63:0] offs, delta, dif, q, mag, mean_next;
  logic [62:0] pk;
  logic [1:0]  act;

  assign out_free = !out_ch.valid || out_ch.ready;
  // The next item is taken only once the held one has updated the state.
  assign q_ready = !s1;
  assign take = q_valid && q_ready;
  assign fire2 = s1 && out_free;

  // First step: discontinuity checks against current timeline state.
  always_comb begin
    chg = ($signed(q_data.raw) < $signed(prev_raw)) ? prev_raw - q_data.raw
                                                   : q_data.raw - prev_raw;
    back_v = ($signed(q_data.video_time) < $signed(prev_video)) &&
      ($signed({32'd0, cfg.backward_threshold}) < $signed(prev_video - q_data.video_time));
    back_a = ($signed(q_data.audio_time) < $signed(prev_audio)) &&
      ($signed({32'd0, cfg.backward_threshold}) < $signed(prev_audio - q_data.audio_time));
    jump = $signed({32'd0, cfg.jump_threshold}) < $signed(chg);
    need_rb = tl_valid && (back_v || back_a || jump);
  end

  // Second step: decision and statistics.
  always_comb begin
    offs = build1 ? (cfg.align_first ? w1.raw : 64'd0) : tl_offset;
    delta = w1.raw - offs;
    if ($signed({32'd0, cfg.early_threshold}) < $signed(delta)) begin
      act = avsfd_pkg::ACT_WAIT;
    end else if ($signed(delta) < $signed(64'd0 - {32'd0, cfg.late_threshold})) begin
      act = avsfd_pkg::ACT_DROP;
    end else begin
      act = avsfd_pkg::ACT_RENDER;
    end
    dif = delta - mean_store;
    q = dif[63] ? 64'd0 - ((64'd0 - dif) >> 3) : dif >> 3;
    mean_next = (mean_valid && !build1) ? mean_store + q : delta;
    mag = delta[63] ? 64'd0 - delta : delta;
    pk = (delta[63] && mag[63]) ? {63{1'b1}} : mag[62:0];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      w1 <= q_data;
      rb1 <= need_rb;
      build1 <= !tl_valid || need_rb;
    end
    if (rst) begin
      s1 <= 1'b0;
      out_ch.valid <= 1'b0;
      tl_valid <= 1'b0;
      tl_offset <= '0;
      prev_video <= '0;
      prev_audio <= '0;
      prev_raw <= '0;
      mean_valid <= 1'b0;
      mean_store <= '0;
      peak_store <= '0;
      c_total <= '0; c_render <= '0; c_wait <= '0;
      c_drop <= '0; c_unsync <= '0; c_rebuild <= '0;
    end else begin
      out_ch.valid <= (out_ch.valid && !out_ch.ready) ||
                      (fire2 && w1.mode == avsfd_pkg::MODE_EVAL);
      if (fire2) s1 <= 1'b0;
      if (take) s1 <= 1'b1;
      if (cfg_wr) begin
        tl_valid <= 1'b0; tl_offset <= '0; prev_video <= '0;
        prev_audio <= '0; prev_raw <= '0; mean_valid <= 1'b0;
      end
      if (fire2) begin
        unique case (w1.mode)
          avsfd_pkg::MODE_RST_TL: begin
            tl_valid <= 1'b0; tl_offset <= '0; prev_video <= '0;
            prev_audio <= '0; prev_raw <= '0; mean_valid <= 1'b0;
          end
          avsfd_pkg::MODE_RST_ST: begin
            c_total <= '0; c_render <= '0; c_wait <= '0;
            c_drop <= '0; c_unsync <= '0; c_rebuild <= '0;
            mean_store <= '0; peak_store <= '0; mean_valid <= 1'b0;
          end
          default: begin
            out_ch.data.synced <= w1.present;
            out_ch.data.rebuilt <= w1.present && rb1;
            out_ch.data.total_count <= 32'(c_total + 1'b1);
            c_total <= c_total + 1'b1;
            if (!w1.present) begin
              out_ch.data.action <= avsfd_pkg::ACT_RENDER;
              out_ch.data.av_delta <= '0;
              out_ch.data.mean_delta <= mean_store;
              out_ch.data.peak_delta <= peak_store;
              out_ch.data.render_count <= 32'(c_render + 1'b1);
              out_ch.data.unsync_count <= 32'(c_unsync + 1'b1);
              out_ch.data.wait_count <= 32'(c_wait);
              out_ch.data.drop_count <= 32'(c_drop);
              out_ch.data.rebuild_count <= 32'(c_rebuild);
              c_render <= c_render + 1'b1;
              c_unsync <= c_unsync + 1'b1;
            end else begin
              out_ch.data.action <= act;
              out_ch.data.av_delta <= delta;
              out_ch.data.mean_delta <= mean_next;
              out_ch.data.peak_delta <= (pk > peak_store) ? pk : peak_store;
              out_ch.data.unsync_count <= 32'(c_unsync);
              out_ch.data.rebuild_count <= 32'(rb1 ? c_rebuild + 1'b1 : c_rebuild);
              out_ch.data.render_count <=
                32'(act == avsfd_pkg::ACT_RENDER ? c_render + 1'b1 : c_render);
              out_ch.data.wait_count <=
                32'(act == avsfd_pkg::ACT_WAIT ? c_wait + 1'b1 : c_wait);
              out_ch.data.drop_count <=
                32'(act == avsfd_pkg::ACT_DROP ? c_drop + 1'b1 : c_drop);
              if (rb1) c_rebuild <= c_rebuild + 1'b1;
              if (act == avsfd_pkg::ACT_RENDER) c_render <= c_render + 1'b1;
              if (act == avsfd_pkg::ACT_WAIT) c_wait <= c_wait + 1'b1;
              if (act == avsfd_pkg::ACT_DROP) c_drop <= c_drop + 1'b1;
              mean_store <= mean_next;
              mean_valid <= 1'b1;
              if (pk > peak_store) peak_store <= pk;
              tl_valid <= 1'b1;
              tl_offset <= offs;
              prev_video <= w1.video_time;
              prev_audio <= w1.audio_time;
              prev_raw <= w1.raw;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: src/av_sync_frame_decider_top.sv
// Audio-video frame decider.
// Items enter on in_ch (valid/ready) carrying a mode, video and audio
// timestamps and an audio-present flag. An evaluate item gives one result
// item on out_ch with the action, the corrected delta and the statistics
// after that frame; reset-timeline and reset-statistics items give none.
// A front stage works out the raw delta and places the item in a two-entry
// queue. The back stage checks for discontinuities in its first step and
// decides and updates the statistics in its second, registering the result.
// An item passes the queue, the stage-one and the result registers. The
// back stage holds one item at a time and takes no new one until the held
// one has updated the state. When out_ch stalls the result register holds,
// the back stage waits and the queue fills, after which in_ch ready falls.
// Reset (rst, synchronous) restores the register defaults, clears the
// timeline, the statistics and the queue. A write to one of the five
// APB registers also clears the timeline; writes are to be made only
// while the block is idle.
module av_sync_frame_decider_top #(
  parameter int COUNT_WIDTH = avsfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  avsfd_in_if.sink    in_ch,
  avsfd_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "av_sync_frame_decider_top_assert.svh"

  avsfd_pkg::cfg_t  cfg;
  avsfd_pkg::work_t q_data;
  logic             q_valid;
  logic             q_ready;
  logic             wr;
  logic             hit;
  logic [2:0]       idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign hit = (paddr[1:0] == 2'd0) && (idx <= avsfd_pkg::REG_ALIGN);
  assign wr = psel && penable && pwrite && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.early_threshold <= 32'd40000;
      cfg.late_threshold <= 32'd80000;
      cfg.jump_threshold <= 32'd1000000;
      cfg.backward_threshold <= 32'd500000;
      cfg.align_first <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        avsfd_pkg::REG_EARLY: cfg.early_threshold <= pwdata;
        avsfd_pkg::REG_LATE: cfg.late_threshold <= pwdata;
        avsfd_pkg::REG_JUMP: cfg.jump_threshold <= pwdata;
        avsfd_pkg::REG_BACK: cfg.backward_threshold <= pwdata;
        default: cfg.align_first <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      avsfd_pkg::REG_EARLY: prdata = cfg.early_threshold;
      avsfd_pkg::REG_LATE: prdata = cfg.late_threshold;
      avsfd_pkg::REG_JUMP: prdata = cfg.jump_threshold;
      avsfd_pkg::REG_BACK: prdata = cfg.backward_threshold;
      avsfd_pkg::REG_ALIGN: prdata = {31'd0, cfg.align_first};
      default: prdata = 32'd0;
    endcase
  end

  avsfd_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  avsfd_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .cfg_wr(wr),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .out_ch(out_ch)
  );

  `AVS_ASSERT_IMPL(a_action_code, out_ch.valid,
    out_ch.data.action == avsfd_pkg::ACT_RENDER || out_ch.data.action == avsfd_pkg::ACT_WAIT ||
    out_ch.data.action == avsfd_pkg::ACT_DROP)
  `AVS_ASSERT_IMPL(a_unsync_render, out_ch.valid && !out_ch.data.synced,
    out_ch.data.action == avsfd_pkg::ACT_RENDER && !out_ch.data.rebuilt)
  `AVS_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.data))

endmodule

FILE: bench/tb_av_sync_frame_decider_top.sv
module tb_av_sync_frame_decider_top;
  timeunit 1ns;
  timeprecision 1ps;
  import avsfd_pkg::*;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  avsfd_in_if in_ch ();
  avsfd_out_if out_ch ();

  av_sync_frame_decider_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  cfg_t cfg;
  logic tl_valid, avg_valid;
  logic [63:0] tl_offset, last_video, last_audio, last_raw, avg_acc;
  logic [62:0] peak_acc;
  logic [31:0] n_total, n_render, n_wait, n_drop, n_unsync, n_rebuild;

  out_item_t pending_results[$];
  int mismatches;
  int n_results;
  int n_frames;
  int idle_pct;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit slt(logic [63:0] a, logic [63:0] b);
    return (a ^ SIGN64) < (b ^ SIGN64);
  endfunction

  function automatic void clear_tl();
    tl_valid = 1'b0;
    tl_offset = '0;
    last_video = '0;
    last_audio = '0;
    last_raw = '0;
    avg_valid = 1'b0;
  endfunction

  function automatic void build_tl(logic [63:0] v, logic [63:0] a);
    logic [63:0] r;
    r = v - a;
    tl_offset = cfg.align_first ? r : 64'd0;
    last_video = v;
    last_audio = a;
    last_raw = r;
    tl_valid = 1'b1;
    avg_valid = 1'b0;
  endfunction

  function automatic bit stepped_back(logic [63:0] now, logic [63:0] prev);
    return slt(now, prev) && slt({32'd0, cfg.backward_threshold}, prev - now);
  endfunction

  function automatic void predict_frame(in_item_t it);
    out_item_t r;
    logic [63:0] raw, chg, delta, d, mag, q;
    logic [1:0] act;
    bit reb;
    act = ACT_RENDER;
    delta = '0;
    reb = 1'b0;
    if (it.mode == MODE_RST_TL) begin
      clear_tl();
      return;
    end
    if (it.mode == MODE_RST_ST) begin
      {n_total, n_render, n_wait, n_drop, n_unsync, n_rebuild} = '0;
      avg_acc = '0;
      peak_acc = '0;
      avg_valid = 1'b0;
      return;
    end
    if (it.mode != MODE_EVAL) return;
    n_total++;
    if (!it.audio_present) begin
      n_render++;
      n_unsync++;
    end else begin
      raw = it.video_time - it.audio_time;
      if (!tl_valid) begin
        build_tl(it.video_time, it.audio_time);
      end else begin
        chg = slt(raw, last_raw) ? last_raw - raw : raw - last_raw;
        if (stepped_back(it.video_time, last_video) || stepped_back(it.audio_time, last_audio)
            || slt({32'd0, cfg.jump_threshold}, chg)) begin
          build_tl(it.video_time, it.audio_time);
          reb = 1'b1;
          n_rebuild++;
        end
      end
      delta = raw - tl_offset;
      if (slt({32'd0, cfg.early_threshold}, delta)) act = ACT_WAIT;
      else if (slt(delta, 64'd0 - {32'd0, cfg.late_threshold})) act = ACT_DROP;
      last_video = it.video_time;
      last_audio = it.audio_time;
      last_raw = raw;
      if (act == ACT_WAIT) n_wait++;
      else if (act == ACT_DROP) n_drop++;
      else n_render++;
      if (!avg_valid) begin
        avg_acc = delta;
        avg_valid = 1'b1;
      end else begin
        d = delta - avg_acc;
        if (d[63]) begin
          mag = 64'd0 - d;
          q = 64'd0 - (mag >> 3);
        end else begin
          q = d >> 3;
        end
        avg_acc = avg_acc + q;
      end
      if (delta[63]) begin
        mag = 64'd0 - delta;
        if (mag > MAX63) mag = MAX63;
      end else begin
        mag = delta;
      end
      if (mag[62:0] > peak_acc) peak_acc = mag[62:0];
    end
    r.action = act;
    r.synced = it.audio_present;
    r.rebuilt = reb;
    r.av_delta = delta;
    r.mean_delta = avg_acc;
    r.peak_delta = peak_acc;
    r.total_count = n_total;
    r.render_count = n_render;
    r.wait_count = n_wait;
    r.drop_count = n_drop;
    r.unsync_count = n_unsync;
    r.rebuild_count = n_rebuild;
    pending_results.push_back(r);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [63:0] v, logic [63:0] a, logic pres);
    in_item_t it;
    it.mode = mode;
    it.video_time = v;
    it.audio_time = a;
    it.audio_present = pres;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_frame(it);
    if (mode == MODE_EVAL) n_frames++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_EARLY: cfg.early_threshold = value;
      REG_LATE: cfg.late_threshold = value;
      REG_JUMP: cfg.jump_threshold = value;
      REG_BACK: cfg.backward_threshold = value;
      REG_ALIGN: cfg.align_first = value[0];
      default: ;
    endcase
    if (idx <= REG_ALIGN) clear_tl();
  endtask

  // Result checker and output stall generator.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result item %p", out_ch.data);
        end else if (out_ch.data !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", pending_results[0], out_ch.data);
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_item(MODE_EVAL, 64'd0, 64'd0, 1'b0);
    send_item(MODE_EVAL, rand64(), rand64(), 1'b0);
    send_item(MODE_EVAL, 64'd1000, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd1000 + 64'd50000, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd1000 - 64'd90000, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd5000000, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd0, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd0, 64'd0 - 64'd900000, 1'b1);
    send_item(MODE_EVAL, MAX63, SIGN64, 1'b1);
    send_item(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(MODE_RST_TL, 64'd0, 64'd0, 1'b0);
    send_item(MODE_EVAL, SIGN64, 64'd0, 1'b1);
    send_item(MODE_EVAL, SIGN64 + 64'd10, 64'd0, 1'b1);
    send_item(MODE_RST_ST, 64'd0, 64'd0, 1'b0);
    send_item(MODE_EVAL, 64'd10, 64'd0, 1'b1);
    send_item(MODE_EVAL, 64'd0, SIGN64, 1'b1);
    write_reg(REG_ALIGN, 32'd0);
    send_item(MODE_EVAL, 64'd0, SIGN64, 1'b1);
    send_item(MODE_EVAL, 64'd3, 64'd0, 1'b1);
    write_reg(3'd7, 32'd5);
    send_item(MODE_EVAL, 64'd4, 64'd0, 1'b1);
  endtask

  task automatic test_random_streams(int count);
    logic [63:0] v, a, step;
    int k;
    v = rand64();
    a = v - {{40{1'b0}}, 24'($urandom)};
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0: send_item(MODE_RST_TL, rand64(), rand64(), 1'($urandom));
        1: send_item(MODE_RST_ST, rand64(), rand64(), 1'($urandom));
        2: send_item(MODE_UNUSED, rand64(), rand64(), 1'($urandom));
        3: send_item(MODE_EVAL, rand64(), rand64(), 1'($urandom));
        4: begin
          v = v - 64'($urandom_range(2000000));
          send_item(MODE_EVAL, v, a, 1'b1);
        end
        5: send_item(MODE_EVAL, v, a, 1'b0);
        default: begin
          step = 64'($urandom_range(40000, 30000));
          v = v + step;
          a = a + step + 64'($urandom_range(200000)) - 64'd100000;
          if ($urandom_range(9) == 0) a = a + 64'($urandom_range(3000000));
          send_item(MODE_EVAL, v, a, 1'b1);
        end
      endcase
    end
  endtask

  task automatic test_settings();
    write_reg(REG_EARLY, 32'd0);
    write_reg(REG_LATE, 32'd0);
    write_reg(REG_JUMP, 32'd1);
    write_reg(REG_BACK, 32'd1);
    write_reg(REG_ALIGN, 32'd1);
    test_random_streams(150);
    write_reg(REG_EARLY, 32'hFFFF_FFFF);
    write_reg(REG_LATE, 32'hFFFF_FFFF);
    write_reg(REG_JUMP, 32'hFFFF_FFFF);
    write_reg(REG_BACK, 32'hFFFF_FFFF);
    write_reg(REG_ALIGN, 32'd0);
    test_random_streams(150);
    write_reg(REG_EARLY, $urandom);
    write_reg(REG_LATE, $urandom);
    write_reg(REG_JUMP, $urandom);
    write_reg(REG_BACK, $urandom);
    write_reg(REG_ALIGN, $urandom);
    test_random_streams(150);
    write_reg(REG_EARLY, 32'd40000);
    write_reg(REG_LATE, 32'd80000);
    write_reg(REG_JUMP, 32'd1000000);
    write_reg(REG_BACK, 32'd500000);
    write_reg(REG_ALIGN, 32'd1);
    idle_pct = 0;
    test_random_streams(250);
    idle_pct = 24;
    test_random_streams(600);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    n_results = 0;
    n_frames = 0;
    idle_pct = 24;
    idle_cycles = 0;
    timed_out = 1'b0;
    cfg.early_threshold = 32'd40000;
    cfg.late_threshold = 32'd80000;
    cfg.jump_threshold = 32'd1000000;
    cfg.backward_threshold = 32'd500000;
    cfg.align_first = 1'b1;
    clear_tl();
    avg_acc = '0;
    peak_acc = '0;
    {n_total, n_render, n_wait, n_drop, n_unsync, n_rebuild} = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    if (pending_results.size() != 0) mismatches++;
    $display("Covered %0d frames and %0d checked result items over five register settings.",
             n_frames, n_results);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
